// ----- hdl/mrpt_pkg.sv -----
`default_nettype none
package mrpt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W = 30;

  localparam logic [13:0] RESERVED_KEY = 14'h3fff;
  localparam logic [7:0] UNSET = 8'hff;
  localparam logic [6:0] ADDR_TOP = 7'h7f;
  localparam logic [7:0] STEP_MAX = 8'h7e;
  localparam logic [6:0] CC_DATA_MSB = 7'd6;
  localparam logic [6:0] CC_DATA_LSB = 7'h26;

  localparam logic [3:0] CMD_CLEAR = 4'd0;
  localparam logic [3:0] CMD_SET_ADDR = 4'd1;
  localparam logic [3:0] CMD_UPSERT = 4'd2;
  localparam logic [3:0] CMD_MODIFY = 4'd3;
  localparam logic [3:0] CMD_ERASE = 4'd4;
  localparam logic [3:0] CMD_INC = 4'd5;
  localparam logic [3:0] CMD_DEC = 4'd6;
  localparam logic [3:0] CMD_SET_LSB = 4'd7;
  localparam logic [3:0] CMD_SET_MSB = 4'd8;
  localparam logic [3:0] CMD_LOOKUP = 4'd9;
  localparam logic [3:0] CMD_DUMP_ALL = 4'd10;
  localparam logic [3:0] CMD_DUMP_ONE = 4'd11;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_CC = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REG_CHANNEL = 1'b0;
  localparam logic REG_CC_BASE = 1'b1;

  typedef struct packed {
    logic [3:0] command;
    logic [6:0] addr_msb;
    logic [6:0] addr_lsb;
    logic [7:0] data_msb;
    logic [7:0] data_lsb;
    logic       restart_run;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] channel;
    logic [6:0] cc_number;
    logic [6:0] cc_value;
    logic       found;
    logic [7:0] found_msb;
    logic [7:0] found_lsb;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/mrpt_ram.sv -----
`default_nettype none
module mrpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/midi_rpn_parameter_table.sv -----
`default_nettype none
// MIDI RPN/NRPN parameter table. Up to 16 entries kept sorted by 14-bit address
// in a single-port-read RAM; one sequencer walks the RAM with one key compare per
// entry. A command is taken when start is high and busy is low. Clear, set-address
// and rejected commands answer in the next cycle and leave busy low. All others
// but dump all first search the entries in key order up to the target; an insert
// or erase then shifts the entries above the target one at a time, a dump reads
// each entry and sends its messages, and the command ends with a final result. Every
// result appears on result for exactly one cycle with result_valid high; the
// receiver cannot stall, so it must take each result when strobed. The final
// result of a command has last set.
module midi_rpn_parameter_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire mrpt_pkg::req_t request,
  output logic               busy,
  output logic               result_valid,
  output mrpt_pkg::res_t     result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_DISPATCH, S_INS_RD, S_INS_WR,
    S_DEL_RD, S_DEL_WR, S_EMIT_RD, S_EMIT_LD, S_EMIT, S_FINISH
  } state_t;

  state_t state;
  logic [3:0] cmd;
  logic [13:0] key;
  logic [7:0] dm, dl;
  logic [mrpt_pkg::CNT_W-1:0] count, idx, pos;
  logic hit, dump_all;
  logic [mrpt_pkg::ENTRY_W-1:0] ent, wr_val;
  logic [13:0] cur_addr, last_sent;
  logic [3:0] channel;
  logic [6:0] cc_base;
  logic [1:0] sub;
  logic pend_valid;
  mrpt_pkg::res_t pend;

  logic ram_we;
  logic [mrpt_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
  logic [mrpt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  mrpt_ram #(.WIDTH(mrpt_pkg::ENTRY_W), .DEPTH(mrpt_pkg::TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == mrpt_pkg::REG_CC_BASE) prdata[6:0] = cc_base;
    else prdata[3:0] = channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= '0;
      cc_base <= 7'd100;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mrpt_pkg::REG_CHANNEL) channel <= pwdata[3:0];
      else cc_base <= pwdata[6:0];
    end
  end

  // updated entry value for the writing commands
  logic [7:0] m, l, m_step, l_step;
  logic [mrpt_pkg::ENTRY_W-1:0] upd;
  logic is_write_cmd, is_insert_cmd;

  always_comb begin
    m = ent[15:8];
    l = ent[7:0];
    m_step = m;
    l_step = l;
    if (cmd == mrpt_pkg::CMD_INC) begin
      if (l <= mrpt_pkg::STEP_MAX) l_step = l + 8'd1;
      else if (m <= mrpt_pkg::STEP_MAX) begin
        m_step = m + 8'd1;
        l_step = 8'd0;
      end
    end else begin
      if (l != 8'd0) l_step = l - 8'd1;
      else if (m != 8'd0) begin
        m_step = m - 8'd1;
        l_step = 8'h7f;
      end
    end
    case (cmd)
      mrpt_pkg::CMD_INC, mrpt_pkg::CMD_DEC: upd = {ent[29:16], m_step, l_step};
      mrpt_pkg::CMD_SET_LSB: upd = hit ? {ent[29:8], dl} : {key, mrpt_pkg::UNSET, dl};
      mrpt_pkg::CMD_SET_MSB:
        upd = hit ? {ent[29:16], dm, ent[7:0]} : {key, dm, mrpt_pkg::UNSET};
      default: upd = {key, dm, dl};
    endcase
    is_write_cmd = (cmd == mrpt_pkg::CMD_UPSERT) || (cmd == mrpt_pkg::CMD_MODIFY) ||
                   (cmd == mrpt_pkg::CMD_INC) || (cmd == mrpt_pkg::CMD_DEC) ||
                   (cmd == mrpt_pkg::CMD_SET_LSB) || (cmd == mrpt_pkg::CMD_SET_MSB);
    is_insert_cmd = (cmd == mrpt_pkg::CMD_UPSERT) || (cmd == mrpt_pkg::CMD_SET_LSB) ||
                    (cmd == mrpt_pkg::CMD_SET_MSB);
  end

  logic [mrpt_pkg::CNT_W-1:0] idx_m1, idx_p1;
  assign idx_m1 = idx - 1'b1;
  assign idx_p1 = idx + 1'b1;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pos[mrpt_pkg::IDX_W-1:0];
    ram_wdata = upd;
    ram_raddr = idx[mrpt_pkg::IDX_W-1:0];
    case (state)
      S_DISPATCH: ram_we = hit && is_write_cmd;
      S_INS_RD: begin
        ram_raddr = idx_m1[mrpt_pkg::IDX_W-1:0];
        if (idx == pos) begin
          ram_we = 1'b1;
          ram_wdata = wr_val;
        end
      end
      S_INS_WR, S_DEL_WR: begin
        ram_we = 1'b1;
        ram_waddr = idx[mrpt_pkg::IDX_W-1:0];
        ram_wdata = ram_rdata;
      end
      S_DEL_RD: ram_raddr = idx_p1[mrpt_pkg::IDX_W-1:0];
      default: ;
    endcase
  end

  // one controller message per emit step, if that byte needs sending
  logic msg_on;
  mrpt_pkg::res_t msg;
  always_comb begin
    msg = '0;
    msg.kind = mrpt_pkg::KIND_CC;
    msg.channel = channel;
    msg_on = 1'b0;
    case (sub)
      2'd0: begin
        msg_on = (last_sent[13:7] != ent[29:23]);
        msg.cc_number = cc_base + 7'd1;
        msg.cc_value = ent[29:23];
      end
      2'd1: begin
        msg_on = (last_sent[6:0] != ent[22:16]);
        msg.cc_number = cc_base;
        msg.cc_value = ent[22:16];
      end
      2'd2: begin
        msg_on = (ent[15:8] != mrpt_pkg::UNSET);
        msg.cc_number = mrpt_pkg::CC_DATA_MSB;
        msg.cc_value = ent[14:8];
      end
      default: begin
        msg_on = (ent[7:0] != mrpt_pkg::UNSET);
        msg.cc_number = mrpt_pkg::CC_DATA_LSB;
        msg.cc_value = ent[6:0];
      end
    endcase
  end

  function automatic mrpt_pkg::res_t ack(input logic [1:0] st);
    mrpt_pkg::res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  logic [13:0] in_key;
  assign in_key = {request.addr_msb, request.addr_lsb};

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cur_addr <= '0;
      last_sent <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= request.command;
            dm <= request.data_msb;
            dl <= request.data_lsb;
            idx <= '0;
            pend_valid <= 1'b0;
            key <= in_key;
            if ((request.command >= mrpt_pkg::CMD_INC) &&
                (request.command <= mrpt_pkg::CMD_SET_MSB)) begin
              key <= cur_addr;
            end
            case (request.command)
              mrpt_pkg::CMD_CLEAR: begin
                count <= '0;
                cur_addr <= '0;
                result_valid <= 1'b1;
                result <= ack(mrpt_pkg::ST_DONE);
              end
              mrpt_pkg::CMD_SET_ADDR: begin
                cur_addr <= in_key;
                result_valid <= 1'b1;
                result <= ack(mrpt_pkg::ST_DONE);
              end
              mrpt_pkg::CMD_UPSERT: begin
                if (in_key == mrpt_pkg::RESERVED_KEY) begin
                  result_valid <= 1'b1;
                  result <= ack(mrpt_pkg::ST_IGNORED);
                end else state <= S_SRCH_RD;
              end
              mrpt_pkg::CMD_INC, mrpt_pkg::CMD_DEC: begin
                if (cur_addr == mrpt_pkg::RESERVED_KEY) begin
                  result_valid <= 1'b1;
                  result <= ack(mrpt_pkg::ST_IGNORED);
                end else state <= S_SRCH_RD;
              end
              mrpt_pkg::CMD_SET_LSB: begin
                if (request.data_lsb[7] || cur_addr[13:7] == mrpt_pkg::ADDR_TOP) begin
                  result_valid <= 1'b1;
                  result <= ack(mrpt_pkg::ST_IGNORED);
                end else state <= S_SRCH_RD;
              end
              mrpt_pkg::CMD_SET_MSB: begin
                if (request.data_msb[7] || cur_addr[13:7] == mrpt_pkg::ADDR_TOP) begin
                  result_valid <= 1'b1;
                  result <= ack(mrpt_pkg::ST_IGNORED);
                end else state <= S_SRCH_RD;
              end
              mrpt_pkg::CMD_MODIFY, mrpt_pkg::CMD_ERASE, mrpt_pkg::CMD_LOOKUP:
                state <= S_SRCH_RD;
              mrpt_pkg::CMD_DUMP_ALL: begin
                last_sent <= '0;
                dump_all <= 1'b1;
                state <= S_EMIT_RD;
              end
              mrpt_pkg::CMD_DUMP_ONE: begin
                if (request.restart_run) last_sent <= '0;
                dump_all <= 1'b0;
                state <= S_SRCH_RD;
              end
              default: begin
                result_valid <= 1'b1;
                result <= ack(mrpt_pkg::ST_IGNORED);
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          if (idx >= count) begin
            pos <= idx;
            hit <= 1'b0;
            state <= S_DISPATCH;
          end else state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (ram_rdata[29:16] < key) begin
            idx <= idx_p1;
            state <= S_SRCH_RD;
          end else begin
            pos <= idx;
            hit <= (ram_rdata[29:16] == key);
            ent <= ram_rdata;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= S_IDLE;
          result_valid <= 1'b1;
          result <= ack(hit ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_IGNORED);
          case (cmd)
            mrpt_pkg::CMD_UPSERT, mrpt_pkg::CMD_SET_LSB, mrpt_pkg::CMD_SET_MSB: begin
              if (!hit) begin
                if (count >= mrpt_pkg::CNT_W'(mrpt_pkg::TABLE_DEPTH)) begin
                  result <= ack(mrpt_pkg::ST_FULL);
                end else begin
                  result_valid <= 1'b0;
                  wr_val <= upd;
                  idx <= count;
                  state <= S_INS_RD;
                end
              end
            end
            mrpt_pkg::CMD_ERASE: begin
              if (hit) begin
                result_valid <= 1'b0;
                idx <= pos;
                state <= S_DEL_RD;
              end
            end
            mrpt_pkg::CMD_LOOKUP: begin
              result <= '0;
              result.kind <= mrpt_pkg::KIND_LOOKUP;
              result.found <= hit;
              result.found_msb <= hit ? ent[15:8] : mrpt_pkg::UNSET;
              result.found_lsb <= hit ? ent[7:0] : mrpt_pkg::UNSET;
              result.status <= hit ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_IGNORED;
              result.last <= 1'b1;
            end
            mrpt_pkg::CMD_DUMP_ONE: begin
              if (hit) begin
                result_valid <= 1'b0;
                sub <= 2'd0;
                state <= S_EMIT;
              end
            end
            default: ;
          endcase
        end
        S_INS_RD: begin
          if (idx == pos) begin
            count <= count + 1'b1;
            result_valid <= 1'b1;
            result <= ack(mrpt_pkg::ST_DONE);
            state <= S_IDLE;
          end else state <= S_INS_WR;
        end
        S_INS_WR: begin
          idx <= idx_m1;
          state <= S_INS_RD;
        end
        S_DEL_RD: begin
          if (idx_p1 >= count) begin
            count <= count - 1'b1;
            result_valid <= 1'b1;
            result <= ack(mrpt_pkg::ST_DONE);
            state <= S_IDLE;
          end else state <= S_DEL_WR;
        end
        S_DEL_WR: begin
          idx <= idx_p1;
          state <= S_DEL_RD;
        end
        S_EMIT_RD: begin
          if (idx >= count) state <= S_FINISH;
          else state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          ent <= ram_rdata;
          sub <= 2'd0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          // hold one message back so the final one can carry last
          if (msg_on) begin
            pend <= msg;
            pend_valid <= 1'b1;
            if (pend_valid) begin
              result_valid <= 1'b1;
              result <= pend;
            end
          end
          sub <= sub + 2'd1;
          if (sub == 2'd3) begin
            last_sent <= ent[29:16];
            if (dump_all) begin
              idx <= idx_p1;
              state <= S_EMIT_RD;
            end else state <= S_FINISH;
          end
        end
        S_FINISH: begin
          result_valid <= 1'b1;
          if (pend_valid) begin
            result <= pend;
            result.last <= 1'b1;
          end else result <= ack(mrpt_pkg::ST_DONE);
          pend_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= mrpt_pkg::CNT_W'(mrpt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_lookup_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == mrpt_pkg::KIND_LOOKUP |-> result.last)
    else $error("lookup answer not marked last");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH |=> result_valid && result.last && state == S_IDLE)
    else $error("dump finish gave no final result");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("held message left over in idle");

endmodule
`default_nettype wire

// ----- sim/midi_rpn_parameter_table_tb.sv -----
`default_nettype none
module midi_rpn_parameter_table_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  mrpt_pkg::req_t request = '0;
  logic busy;
  logic result_valid;
  mrpt_pkg::res_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  midi_rpn_parameter_table u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request), .busy(busy),
    .result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the parameter table
  logic [29:0] tbl [mrpt_pkg::TABLE_DEPTH];
  int unsigned tbl_cnt;
  logic [13:0] cur_addr;
  logic [13:0] sent_addr;
  logic [3:0] chan_reg;
  logic [6:0] base_reg;
  mrpt_pkg::res_t expected_results [$];
  int errors = 0;
  int mismatches = 0;
  bit quiet = 1'b0;

  function automatic mrpt_pkg::res_t ack_res(logic [1:0] st);
    mrpt_pkg::res_t r;
    r = '0;
    r.kind = mrpt_pkg::KIND_ACK;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic mrpt_pkg::res_t cc_res(logic [6:0] num, logic [6:0] val);
    mrpt_pkg::res_t r;
    r = '0;
    r.kind = mrpt_pkg::KIND_CC;
    r.channel = chan_reg;
    r.cc_number = num;
    r.cc_value = val;
    return r;
  endfunction

  function automatic int unsigned lower_pos(logic [13:0] key);
    int unsigned i;
    i = 0;
    while (i < tbl_cnt && tbl[i][29:16] < key) i++;
    return i;
  endfunction

  function automatic bit hit(int unsigned p, logic [13:0] key);
    return p < tbl_cnt && tbl[p][29:16] == key;
  endfunction

  function automatic logic [1:0] insert_at(int unsigned p, logic [13:0] key,
                                           logic [7:0] m, logic [7:0] l);
    if (tbl_cnt >= mrpt_pkg::TABLE_DEPTH) return mrpt_pkg::ST_FULL;
    for (int unsigned i = tbl_cnt; i > p; i--) tbl[i] = tbl[i-1];
    tbl[p] = {key, m, l};
    tbl_cnt++;
    return mrpt_pkg::ST_DONE;
  endfunction

  function automatic void emit_entry(logic [29:0] e);
    if (sent_addr[13:7] != e[29:23])
      expected_results.push_back(cc_res(base_reg + 7'd1, e[29:23]));
    if (sent_addr[6:0] != e[22:16])
      expected_results.push_back(cc_res(base_reg, e[22:16]));
    if (e[15:8] != mrpt_pkg::UNSET)
      expected_results.push_back(cc_res(mrpt_pkg::CC_DATA_MSB, e[14:8]));
    if (e[7:0] != mrpt_pkg::UNSET)
      expected_results.push_back(cc_res(mrpt_pkg::CC_DATA_LSB, e[6:0]));
    sent_addr = e[29:16];
  endfunction

  function automatic logic [1:0] set_byte(logic [7:0] v, bit high);
    int unsigned p;
    if (v >= 8'h80 || cur_addr[13:7] == mrpt_pkg::ADDR_TOP) return mrpt_pkg::ST_IGNORED;
    p = lower_pos(cur_addr);
    if (hit(p, cur_addr)) begin
      if (high) tbl[p][15:8] = v;
      else tbl[p][7:0] = v;
      return mrpt_pkg::ST_DONE;
    end
    return high ? insert_at(p, cur_addr, v, mrpt_pkg::UNSET)
                : insert_at(p, cur_addr, mrpt_pkg::UNSET, v);
  endfunction

  function automatic logic [1:0] step_value(bit up);
    int unsigned p;
    logic [7:0] m, l;
    p = lower_pos(cur_addr);
    if (cur_addr == mrpt_pkg::RESERVED_KEY || !hit(p, cur_addr))
      return mrpt_pkg::ST_IGNORED;
    m = tbl[p][15:8];
    l = tbl[p][7:0];
    if (up) begin
      if (l <= mrpt_pkg::STEP_MAX) l++;
      else if (m <= mrpt_pkg::STEP_MAX) begin m++; l = 0; end
    end else begin
      if (l != 0) l--;
      else if (m != 0) begin m--; l = 8'h7f; end
    end
    tbl[p][15:0] = {m, l};
    return mrpt_pkg::ST_DONE;
  endfunction

  function automatic void predict(mrpt_pkg::req_t q);
    logic [13:0] key;
    int unsigned p, n0;
    mrpt_pkg::res_t r;
    key = {q.addr_msb, q.addr_lsb};
    p = lower_pos(key);
    case (q.command)
      mrpt_pkg::CMD_CLEAR: begin
        tbl_cnt = 0;
        cur_addr = '0;
        expected_results.push_back(ack_res(mrpt_pkg::ST_DONE));
      end
      mrpt_pkg::CMD_SET_ADDR: begin
        cur_addr = key;
        expected_results.push_back(ack_res(mrpt_pkg::ST_DONE));
      end
      mrpt_pkg::CMD_UPSERT: begin
        if (key == mrpt_pkg::RESERVED_KEY)
          expected_results.push_back(ack_res(mrpt_pkg::ST_IGNORED));
        else if (hit(p, key)) begin
          tbl[p] = {key, q.data_msb, q.data_lsb};
          expected_results.push_back(ack_res(mrpt_pkg::ST_DONE));
        end else
          expected_results.push_back(ack_res(insert_at(p, key, q.data_msb, q.data_lsb)));
      end
      mrpt_pkg::CMD_MODIFY: begin
        if (!hit(p, key)) expected_results.push_back(ack_res(mrpt_pkg::ST_IGNORED));
        else begin
          tbl[p] = {key, q.data_msb, q.data_lsb};
          expected_results.push_back(ack_res(mrpt_pkg::ST_DONE));
        end
      end
      mrpt_pkg::CMD_ERASE: begin
        if (!hit(p, key)) expected_results.push_back(ack_res(mrpt_pkg::ST_IGNORED));
        else begin
          for (int unsigned i = p; i + 1 < tbl_cnt; i++) tbl[i] = tbl[i+1];
          tbl_cnt--;
          expected_results.push_back(ack_res(mrpt_pkg::ST_DONE));
        end
      end
      mrpt_pkg::CMD_INC: expected_results.push_back(ack_res(step_value(1'b1)));
      mrpt_pkg::CMD_DEC: expected_results.push_back(ack_res(step_value(1'b0)));
      mrpt_pkg::CMD_SET_LSB:
        expected_results.push_back(ack_res(set_byte(q.data_lsb, 1'b0)));
      mrpt_pkg::CMD_SET_MSB:
        expected_results.push_back(ack_res(set_byte(q.data_msb, 1'b1)));
      mrpt_pkg::CMD_LOOKUP: begin
        r = '0;
        r.kind = mrpt_pkg::KIND_LOOKUP;
        r.last = 1'b1;
        if (hit(p, key)) begin
          r.found = 1'b1;
          r.found_msb = tbl[p][15:8];
          r.found_lsb = tbl[p][7:0];
        end else begin
          r.found_msb = mrpt_pkg::UNSET;
          r.found_lsb = mrpt_pkg::UNSET;
          r.status = mrpt_pkg::ST_IGNORED;
        end
        expected_results.push_back(r);
      end
      mrpt_pkg::CMD_DUMP_ALL, mrpt_pkg::CMD_DUMP_ONE: begin
        n0 = expected_results.size();
        if (q.command == mrpt_pkg::CMD_DUMP_ALL) begin
          sent_addr = '0;
          for (int unsigned i = 0; i < tbl_cnt; i++) emit_entry(tbl[i]);
        end else begin
          if (q.restart_run) sent_addr = '0;
          if (!hit(p, key)) begin
            expected_results.push_back(ack_res(mrpt_pkg::ST_IGNORED));
            return;
          end
          emit_entry(tbl[p]);
        end
        if (expected_results.size() == n0)
          expected_results.push_back(ack_res(mrpt_pkg::ST_DONE));
        else expected_results[expected_results.size()-1].last = 1'b1;
      end
      default: expected_results.push_back(ack_res(mrpt_pkg::ST_IGNORED));
    endcase
  endfunction

  always @(posedge clk) begin
    mrpt_pkg::res_t e;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", result);
      end else begin
        e = expected_results.pop_front();
        if (result !== e) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected %h actual %h (kind %0d/%0d status %0d/%0d)",
                     e, result, e.kind, result.kind, e.status, result.status);
        end
      end
    end
  end

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // start stays high into the next request unless a gap drops it
  task automatic send_request(mrpt_pkg::req_t q);
    idle_gap();
    start <= 1'b1;
    request <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(q);
  endtask

  task automatic send_cmd(logic [3:0] c, logic [13:0] key, logic [7:0] m = 8'hff,
                          logic [7:0] l = 8'hff, logic rr = 1'b0);
    mrpt_pkg::req_t q;
    q.command = c;
    q.addr_msb = key[13:7];
    q.addr_lsb = key[6:0];
    q.data_msb = m;
    q.data_lsb = l;
    q.restart_run = rr;
    send_request(q);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == mrpt_pkg::REG_CHANNEL) chan_reg = v[3:0];
    else base_reg = v[6:0];
    @(posedge clk);
  endtask

  task automatic set_config(logic [3:0] ch, logic [6:0] b);
    drain();
    write_reg(mrpt_pkg::REG_CHANNEL, {28'd0, ch});
    write_reg(mrpt_pkg::REG_CC_BASE, {25'd0, b});
  endtask

  function automatic logic [13:0] small_key();
    return {7'($urandom_range(0, 2)), 7'($urandom_range(0, 5))};
  endfunction

  task automatic test_directed();
    send_cmd(mrpt_pkg::CMD_DUMP_ALL, 0);
    send_cmd(mrpt_pkg::CMD_UPSERT, 14'h3fff, 1, 2);
    send_cmd(mrpt_pkg::CMD_UPSERT, 14'h3ffe, 8'hff, 8'h00);
    send_cmd(mrpt_pkg::CMD_UPSERT, 0, 8'h00, 8'h7f);
    send_cmd(mrpt_pkg::CMD_UPSERT, 14'h0085, 8'hc0, 8'h81);
    send_cmd(mrpt_pkg::CMD_MODIFY, 14'h0085, 8'h7f, 8'h7e);
    send_cmd(mrpt_pkg::CMD_MODIFY, 14'h0001, 1, 1);
    send_cmd(mrpt_pkg::CMD_SET_ADDR, 14'h0085);
    send_cmd(mrpt_pkg::CMD_INC, 0);
    send_cmd(mrpt_pkg::CMD_INC, 0);
    send_cmd(mrpt_pkg::CMD_INC, 0);
    send_cmd(mrpt_pkg::CMD_SET_ADDR, 0);
    send_cmd(mrpt_pkg::CMD_DEC, 0);
    send_cmd(mrpt_pkg::CMD_SET_LSB, 0, 8'h00, 8'h00);
    send_cmd(mrpt_pkg::CMD_DEC, 0);
    send_cmd(mrpt_pkg::CMD_SET_MSB, 0, 8'h80, 8'h00);
    send_cmd(mrpt_pkg::CMD_SET_ADDR, 14'h3fff);
    send_cmd(mrpt_pkg::CMD_INC, 0);
    send_cmd(mrpt_pkg::CMD_SET_LSB, 0, 8'h00, 8'h10);
    send_cmd(mrpt_pkg::CMD_LOOKUP, 14'h3ffe);
    send_cmd(mrpt_pkg::CMD_LOOKUP, 14'h1234);
    send_cmd(mrpt_pkg::CMD_DUMP_ONE, 14'h0085, 0, 0, 1'b1);
    send_cmd(mrpt_pkg::CMD_DUMP_ONE, 14'h0085, 0, 0, 1'b0);
    send_cmd(mrpt_pkg::CMD_ERASE, 0);
    send_cmd(mrpt_pkg::CMD_ERASE, 0);
    send_cmd(mrpt_pkg::CMD_DUMP_ALL, 0);
    send_cmd(4'd12, 0);
    send_cmd(4'd15, 14'h3fff);
    send_cmd(mrpt_pkg::CMD_CLEAR, 0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 17; i++)
      send_cmd(mrpt_pkg::CMD_UPSERT, 14'(i * 37), 8'(i), 8'(2 * i));
    send_cmd(mrpt_pkg::CMD_SET_ADDR, 14'h0700);
    send_cmd(mrpt_pkg::CMD_SET_MSB, 0, 8'h05, 0);
    send_cmd(mrpt_pkg::CMD_DUMP_ALL, 0);
    send_cmd(mrpt_pkg::CMD_CLEAR, 0);
  endtask

  task automatic test_random(int n);
    mrpt_pkg::req_t q;
    logic [13:0] k;
    for (int i = 0; i < n; i++) begin
      q = mrpt_pkg::req_t'($urandom);
      k = ($urandom_range(0, 9) < 8) ? small_key() : 14'($urandom);
      q.addr_msb = k[13:7];
      q.addr_lsb = k[6:0];
      case ($urandom_range(0, 9))
        0, 1, 2: q.command = mrpt_pkg::CMD_UPSERT;
        3: q.command = 4'($urandom_range(mrpt_pkg::CMD_SET_ADDR, mrpt_pkg::CMD_SET_MSB));
        4: q.command = ($urandom_range(0, 1)) ? mrpt_pkg::CMD_INC : mrpt_pkg::CMD_DEC;
        5: q.command = ($urandom_range(0, 1)) ? mrpt_pkg::CMD_SET_LSB
                                              : mrpt_pkg::CMD_SET_MSB;
        6: q.command = mrpt_pkg::CMD_LOOKUP;
        7: q.command = ($urandom_range(0, 3) == 0) ? mrpt_pkg::CMD_DUMP_ALL
                                                   : mrpt_pkg::CMD_DUMP_ONE;
        8: q.command = ($urandom_range(0, 20) == 0) ? mrpt_pkg::CMD_CLEAR
                                                    : mrpt_pkg::CMD_ERASE;
        default: q.command = 4'($urandom);
      endcase
      if ($urandom_range(0, 1)) q.data_msb = 8'($urandom_range(0, 127));
      if ($urandom_range(0, 1)) q.data_lsb = 8'($urandom_range(0, 127));
      send_request(q);
    end
  endtask

  initial begin
    tbl_cnt = 0;
    cur_addr = '0;
    sent_addr = '0;
    chan_reg = 4'd0;
    base_reg = 7'd100;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_config(4'd15, 7'd127);
    test_table_full();
    test_random(55);
    set_config(4'd0, 7'd0);
    test_random(55);
    set_config(4'($urandom), 7'($urandom));
    test_random(30);
    quiet = 1'b1;
    test_random(20);
    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/mrpt_pkg.sv
hdl/mrpt_ram.sv
hdl/midi_rpn_parameter_table.sv
sim/midi_rpn_parameter_table_tb.sv
